>>> hdl/sepq_pkg.sv
package sepq_pkg;

    // Fixed widths of the channel fields
    localparam int IN_TIME_W  = 32;
    localparam int IN_ID_W    = 8;
    localparam int OUT_TIME_W = 32;
    localparam int OUT_ID_W   = 8;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_POP    = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // One result transaction as produced by the queue core
    typedef struct packed {
        logic                  out_valid;
        logic [OUT_TIME_W-1:0] out_time;
        logic [OUT_ID_W-1:0]   out_id;
        logic [OUT_TIME_W-1:0] head_time;
        logic                  queue_empty;
        status_t               status;
    } result_t;

endpackage

>>> hdl/sepq_cmd_if.sv
interface sepq_cmd_if
    import sepq_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [IN_TIME_W-1:0] action_time;
    logic [IN_ID_W-1:0]   proc_id;

    modport source (output valid, output mode, output action_time, output proc_id,
                    input ready);
    modport sink   (input valid, input mode, input action_time, input proc_id,
                    output ready);
endinterface

>>> hdl/sepq_rsp_if.sv
interface sepq_rsp_if
    import sepq_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic                  out_valid;
    logic [OUT_TIME_W-1:0] out_time;
    logic [OUT_ID_W-1:0]   out_id;
    logic [OUT_TIME_W-1:0] head_time;
    logic                  queue_empty;
    logic [1:0]            status;

    modport source (output valid, output out_valid, output out_time, output out_id,
                    output head_time, output queue_empty, output status,
                    input ready);
    modport sink   (input valid, input out_valid, input out_time, input out_id,
                    input head_time, input queue_empty, input status,
                    output ready);
endinterface

>>> hdl/sepq_queue.sv
module sepq_queue
    import sepq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 32,
    parameter int ID_BITS     = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  mode_t                op_mode,
    input  logic [TIME_BITS-1:0] key_time,
    input  logic [ID_BITS-1:0]   key_id,
    output result_t              result
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [TIME_BITS-1:0] time_reg [QUEUE_DEPTH];
    logic [ID_BITS-1:0]   id_reg   [QUEUE_DEPTH];
    logic [TIME_BITS-1:0] time_next [QUEUE_DEPTH];
    logic [ID_BITS-1:0]   id_next   [QUEUE_DEPTH];
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    // ge[i]: slot i sits at or after the insert position (thermometer)
    logic [QUEUE_DEPTH-1:0] ge;
    logic                   full;
    logic                   empty;
    logic                   do_insert;
    logic                   do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_insert = fire && (op_mode == MODE_INSERT) && !full;
    assign do_pop    = fire && (op_mode == MODE_POP) && !empty;

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (CNT_W'(i) < count_reg)
            begin
                ge[i] = (time_reg[i] > key_time) ||
                        ((time_reg[i] == key_time) && (id_reg[i] > key_id));
            end
            else
            begin
                ge[i] = 1'b1;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            time_next[i] = time_reg[i];
            id_next[i]   = id_reg[i];
        end
        if (do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                if (ge[i])
                begin
                    if (i > 0 && ge[(i > 0) ? i - 1 : 0])
                    begin
                        time_next[i] = time_reg[(i > 0) ? i - 1 : 0];
                        id_next[i]   = id_reg[(i > 0) ? i - 1 : 0];
                    end
                    else
                    begin
                        time_next[i] = key_time;
                        id_next[i]   = key_id;
                    end
                end
            end
        end
        else if (do_pop)
        begin
            count_next = count_reg - CNT_W'(1);
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                time_next[i] = time_reg[i + 1];
                id_next[i]   = id_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (fire)
        begin
            count_reg <= count_next;
        end
    end

    // entry storage is undefined until written, no reset
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                time_reg[i] <= time_next[i];
                id_reg[i]   <= id_next[i];
            end
        end
    end

    always_comb
    begin
        result.out_valid   = do_pop;
        result.out_time    = do_pop ? OUT_TIME_W'(time_reg[0]) : '0;
        result.out_id      = do_pop ? OUT_ID_W'(id_reg[0]) : '0;
        result.queue_empty = (count_next == '0);
        result.head_time   = (count_next == '0) ? '0 : OUT_TIME_W'(time_next[0]);
        if (op_mode == MODE_INSERT && full)
        begin
            result.status = STATUS_FULL;
        end
        else if (op_mode == MODE_POP && empty)
        begin
            result.status = STATUS_EMPTY;
        end
        else
        begin
            result.status = STATUS_OK;
        end
    end

endmodule

>>> hdl/sorted_event_priority_queue.sv
// Sorted event priority queue. Holds up to QUEUE_DEPTH entries of (event time,
// process id) in ascending time order, ties broken by ascending id; an entry
// equal to a queued one lands behind it. A command transaction with mode 0
// inserts its entry, mode 1 pops the head. Every command yields exactly one
// response transaction carrying the popped entry (out_valid set on a good pop),
// the head time and empty flag after the operation, and a status: ok, insert
// dropped on a full queue, or pop on an empty queue. Throughput is one command
// per clock unless the output stalls: each command waits in the input register,
// then all slots compare against the key in parallel and shift one place while
// the response is loaded into the output register. A stalled output register
// holds the command in the input register, which then holds off further
// commands. The output register takes a new response in the cycle its current
// one is taken, so back-to-back commands flow without bubbles. Times wider than
// TIME_BITS and ids wider than ID_BITS are truncated on entry. Entry contents
// are not reset; only the fill count is.
module sorted_event_priority_queue
    import sepq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 32,
    parameter int ID_BITS     = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    sepq_cmd_if.sink          cmd,
    sepq_rsp_if.source        rsp
);

    // Input register
    logic                 cmd_valid_reg;
    logic                 cmd_valid_next;
    logic                 cmd_mode_reg;
    logic [IN_TIME_W-1:0] cmd_time_reg;
    logic [IN_ID_W-1:0]   cmd_id_reg;

    // Output register
    logic    rsp_valid_reg;
    logic    rsp_valid_next;
    result_t rsp_reg;

    result_t result;
    logic    out_load;
    logic    advance;
    logic    cmd_take;

    // Output register frees up when empty or when its transaction is taken
    assign out_load = !rsp_valid_reg || rsp.ready;
    assign advance  = cmd_valid_reg && out_load;
    assign cmd.ready = !cmd_valid_reg || advance;
    assign cmd_take  = cmd.valid && cmd.ready;

    always_comb
    begin
        if (cmd_take)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (advance)
        begin
            cmd_valid_next = 1'b0;
        end
        else
        begin
            cmd_valid_next = cmd_valid_reg;
        end

        if (advance)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cmd_mode_reg <= cmd.mode;
            cmd_time_reg <= cmd.action_time;
            cmd_id_reg   <= cmd.proc_id;
        end
        if (advance)
        begin
            rsp_reg <= result;
        end
    end

    // Compare-and-shift core; queue state moves when the command advances
    sepq_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS),
        .ID_BITS     (ID_BITS)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (advance),
        .op_mode  (mode_t'(cmd_mode_reg)),
        .key_time (TIME_BITS'(cmd_time_reg)),
        .key_id   (ID_BITS'(cmd_id_reg)),
        .result   (result)
    );

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.out_valid   = rsp_reg.out_valid;
    assign rsp.out_time    = rsp_reg.out_time;
    assign rsp.out_id      = rsp_reg.out_id;
    assign rsp.head_time   = rsp_reg.head_time;
    assign rsp.queue_empty = rsp_reg.queue_empty;
    assign rsp.status      = rsp_reg.status;

endmodule
